FILE: rtl/bed_pkg.sv
// Shared constants, types and helper functions of the backslash escape decoder.
package bed_pkg;

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhBs   = 3'd1;
  localparam logic [2:0] PhX0   = 3'd2;
  localparam logic [2:0] PhX1   = 3'd3;
  localparam logic [2:0] PhO1   = 3'd4;
  localparam logic [2:0] PhO2   = 3'd5;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChX         = 8'h78;
  localparam logic [7:0] ChE         = 8'h65;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] Ch0         = 8'h30;
  localparam logic [7:0] Ch3         = 8'h33;
  localparam logic [7:0] Ch7         = 8'h37;
  localparam logic [7:0] Ch9         = 8'h39;
  localparam logic [7:0] ChLowA      = 8'h61;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChUpA       = 8'h41;
  localparam logic [7:0] ChUpF       = 8'h46;

  localparam logic [7:0] CodeEsc = 8'h1B;
  localparam logic [7:0] CodeFf  = 8'h0C;
  localparam logic [7:0] CodeLf  = 8'h0A;
  localparam logic [7:0] CodeCr  = 8'h0D;
  localparam logic [7:0] CodeTab = 8'h09;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } burst_t;

  // Returns a valid flag above the four-bit value of a hex digit.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= Ch0 && c <= Ch9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= ChLowA && c <= ChLowF) || (c >= ChUpA && c <= ChUpF)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // Bytes of an open escape, emitted unchanged when it is abandoned.
  function automatic burst_t flush_burst(logic [2:0] phase, logic [7:0] h0, logic [7:0] h1);
    burst_t b;
    b = '0;
    case (phase)
      PhBs: begin
        b.bytes[0] = ChBackslash;
        b.count    = 3'd1;
      end
      PhX0: begin
        b.bytes[0] = ChBackslash;
        b.bytes[1] = ChX;
        b.count    = 3'd2;
      end
      PhX1: begin
        b.bytes[0] = ChBackslash;
        b.bytes[1] = ChX;
        b.bytes[2] = h0;
        b.count    = 3'd3;
      end
      PhO1: begin
        b.bytes[0] = ChBackslash;
        b.bytes[1] = h0;
        b.count    = 3'd2;
      end
      PhO2: begin
        b.bytes[0] = ChBackslash;
        b.bytes[1] = h0;
        b.bytes[2] = h1;
        b.count    = 3'd3;
      end
      default: begin
        b.count = 3'd0;
      end
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/bed_in_if.sv
// Request channel carrying raw escaped characters into the decoder.
interface bed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/bed_out_if.sv
// Request channel carrying decoded characters out of the decoder.
interface bed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: rtl/backslash_escape_decoder.sv
// Top level of the backslash escape decoder.
//
// Raw characters enter on in_i, one request per character, with in_last
// marking the end of a string. Decoded characters leave on out_o with
// out_last on the final decoded character of each string.
// An accepted character is decoded in the same cycle and its results
// (zero to four bytes) are loaded into an output group register, so the
// first result appears in the cycle after acceptance.
// A character that yields at most one byte can follow in the next cycle,
// giving one character per cycle while the receiver takes every byte.
// When a character yields n bytes, the group register drains one byte per
// cycle while the receiver is ready, and the input takes the next character
// in the cycle the last of those bytes is taken.
// Reset clears the escape state and empties the group register.
// When the receiver stalls, the current byte holds on out_o and the
// input stays blocked until the last queued byte is taken.
module backslash_escape_decoder (
  input logic      clk_i,
  input logic      rst_ni,
  bed_in_if.sink   in_i,
  bed_out_if.source out_o
);

  logic [2:0]      phase_q, phase_d;
  logic [7:0]      held0_q, held0_d;
  logic [7:0]      held1_q, held1_d;
  logic [4:0]      digit_value_q, digit_value_d;
  logic [3:0][7:0] group_q, group_d;
  logic [2:0]      count_q;
  logic [2:0]      total_d;
  logic [1:0]      ptr_q;
  logic            last_q;

  logic [4:0]      hex;
  logic            is_oct;
  logic            consumed;
  bed_pkg::burst_t feed;
  bed_pkg::burst_t tail;
  logic [2:0]      tail_idx;
  logic [3:0]      sum;
  logic            accept;
  logic            pop;

  assign hex    = bed_pkg::hex_digit(in_i.in_byte);
  assign is_oct = (in_i.in_byte >= bed_pkg::Ch0) && (in_i.in_byte <= bed_pkg::Ch7);

  always_comb begin
    phase_d       = phase_q;
    held0_d       = held0_q;
    held1_d       = held1_q;
    digit_value_d = digit_value_q;
    consumed      = 1'b0;
    feed          = '0;
    case (phase_q)
      bed_pkg::PhBs: begin
        consumed = 1'b1;
        phase_d  = bed_pkg::PhIdle;
        feed.count = 3'd1;
        case (in_i.in_byte)
          bed_pkg::ChE:         feed.bytes[0] = bed_pkg::CodeEsc;
          bed_pkg::ChF:         feed.bytes[0] = bed_pkg::CodeFf;
          bed_pkg::ChN:         feed.bytes[0] = bed_pkg::CodeLf;
          bed_pkg::ChR:         feed.bytes[0] = bed_pkg::CodeCr;
          bed_pkg::ChT:         feed.bytes[0] = bed_pkg::CodeTab;
          bed_pkg::ChBackslash: feed.bytes[0] = bed_pkg::ChBackslash;
          bed_pkg::ChX: begin
            feed.count = 3'd0;
            phase_d    = bed_pkg::PhX0;
          end
          default: begin
            feed.count = 3'd0;
            if (in_i.in_byte inside {[bed_pkg::Ch0:bed_pkg::Ch3]}) begin
              held0_d       = in_i.in_byte;
              digit_value_d = {3'b000, in_i.in_byte[1:0]};
              phase_d       = bed_pkg::PhO1;
            end else begin
              consumed = 1'b0;
              phase_d  = phase_q;
            end
          end
        endcase
      end
      bed_pkg::PhX0: begin
        if (hex[4]) begin
          consumed      = 1'b1;
          held0_d       = in_i.in_byte;
          digit_value_d = {1'b0, hex[3:0]};
          phase_d       = bed_pkg::PhX1;
        end
      end
      bed_pkg::PhX1: begin
        if (hex[4]) begin
          consumed      = 1'b1;
          feed.bytes[0] = {digit_value_q[3:0], hex[3:0]};
          feed.count    = 3'd1;
          phase_d       = bed_pkg::PhIdle;
        end
      end
      bed_pkg::PhO1: begin
        if (is_oct) begin
          consumed      = 1'b1;
          held1_d       = in_i.in_byte;
          digit_value_d = {digit_value_q[1:0], in_i.in_byte[2:0]};
          phase_d       = bed_pkg::PhO2;
        end
      end
      bed_pkg::PhO2: begin
        if (is_oct) begin
          consumed      = 1'b1;
          feed.bytes[0] = {digit_value_q, in_i.in_byte[2:0]};
          feed.count    = 3'd1;
          phase_d       = bed_pkg::PhIdle;
        end
      end
      default: begin
        consumed = 1'b0;
      end
    endcase

    // An abandoned escape is emitted as it stood and the byte is scanned afresh.
    if (!consumed) begin
      feed = bed_pkg::flush_burst(phase_q, held0_q, held1_q);
      if (in_i.in_byte == bed_pkg::ChBackslash) begin
        phase_d = bed_pkg::PhBs;
      end else begin
        feed.bytes[feed.count[1:0]] = in_i.in_byte;
        feed.count = feed.count + 3'd1;
        phase_d    = bed_pkg::PhIdle;
      end
    end

    tail = '0;
    if (in_i.in_last) begin
      tail    = bed_pkg::flush_burst(phase_d, held0_d, held1_d);
      phase_d = bed_pkg::PhIdle;
    end

    group_d = '0;
    for (int k = 0; k < 4; k++) begin
      tail_idx = 3'(k) - feed.count;
      if (3'(k) < feed.count) begin
        group_d[k] = feed.bytes[k];
      end else begin
        group_d[k] = tail.bytes[tail_idx[1:0]];
      end
    end
    sum = {1'b0, feed.count} + {1'b0, tail.count};
    if (sum > 4'd4) begin
      total_d = 3'd4;
    end else begin
      total_d = sum[2:0];
    end
  end

  assign in_i.ready     = (count_q == 3'd0) || ((count_q == 3'd1) && out_o.ready);
  assign accept         = in_i.valid && in_i.ready;
  assign out_o.valid    = (count_q != 3'd0);
  assign out_o.out_byte = group_q[ptr_q];
  assign out_o.out_last = last_q && (count_q == 3'd1);
  assign pop            = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bed_pkg::PhIdle;
      count_q <= 3'd0;
      ptr_q   <= 2'd0;
      last_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      count_q <= total_d;
      ptr_q   <= 2'd0;
      last_q  <= in_i.in_last;
    end else if (pop) begin
      count_q <= count_q - 3'd1;
      ptr_q   <= ptr_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held0_q       <= held0_d;
      held1_q       <= held1_d;
      digit_value_q <= digit_value_d;
      group_q       <= group_d;
    end
  end

endmodule

FILE: rtl/bed_checker.sv
// Port-level assertions of the backslash escape decoder and their binding.
module bed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output request dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(out_last_i))
    else $error("output payload changed while stalled");

  // With nothing queued for output, the decoder takes input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // The end of a string always produces at least one decoded byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i)
    else $error("string end produced no output");

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_last_i  (in_i.in_last),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_byte_i (out_o.out_byte),
  .out_last_i (out_o.out_last)
);

FILE: tb/testbench.sv
// Self-checking testbench for the backslash escape decoder with a built-in decode predictor.
module testbench;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } dec_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bed_in_if  in_if();
  bed_out_if out_if();

  backslash_escape_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state, kept apart from the design.
  logic [2:0] esc_phase = bed_pkg::PhIdle;
  logic [7:0] esc_value = '0;
  logic [7:0] held_lo   = '0;
  logic [7:0] held_hi   = '0;
  logic [7:0] step_bytes[4];
  int         step_n;
  dec_char_t  decoded_q[$];
  dec_char_t  want_char;
  logic [7:0] gen_text[$];

  int unsigned chars_sent   = 0;
  int unsigned strings_sent = 0;
  int unsigned results_seen = 0;
  int unsigned err_count    = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;

  logic [1:0] stall_mode  = 2'd0;
  logic [3:0] stall_phase = '0;
  int         mode_cycles = 0;

  function automatic void put_byte(logic [7:0] b);
    if (step_n < 4) begin
      step_bytes[step_n] = b;
      step_n++;
    end
  endfunction

  function automatic void add_gen(logic [7:0] b);
    gen_text.insert(gen_text.size(), b);
  endfunction

  function automatic int hex_nibble(logic [7:0] ch);
    if (ch >= bed_pkg::Ch0 && ch <= bed_pkg::Ch9) return int'(ch - bed_pkg::Ch0);
    if (ch >= bed_pkg::ChLowA && ch <= bed_pkg::ChLowF) return int'(ch - bed_pkg::ChLowA) + 10;
    if (ch >= bed_pkg::ChUpA && ch <= bed_pkg::ChUpF) return int'(ch - bed_pkg::ChUpA) + 10;
    return -1;
  endfunction

  // An abandoned escape goes out exactly as it was received.
  function automatic void abandon_escape();
    case (esc_phase)
      bed_pkg::PhBs: begin
        put_byte(bed_pkg::ChBackslash);
      end
      bed_pkg::PhX0: begin
        put_byte(bed_pkg::ChBackslash);
        put_byte(bed_pkg::ChX);
      end
      bed_pkg::PhX1: begin
        put_byte(bed_pkg::ChBackslash);
        put_byte(bed_pkg::ChX);
        put_byte(held_lo);
      end
      bed_pkg::PhO1: begin
        put_byte(bed_pkg::ChBackslash);
        put_byte(held_lo);
      end
      bed_pkg::PhO2: begin
        put_byte(bed_pkg::ChBackslash);
        put_byte(held_lo);
        put_byte(held_hi);
      end
      default: begin
      end
    endcase
    esc_phase = bed_pkg::PhIdle;
  endfunction

  function automatic void scan_plain(logic [7:0] ch);
    if (ch == bed_pkg::ChBackslash) begin
      esc_phase = bed_pkg::PhBs;
    end else begin
      esc_phase = bed_pkg::PhIdle;
      put_byte(ch);
    end
  endfunction

  function automatic void decode_char(logic [7:0] ch, logic last);
    int        h;
    logic      is_oct;
    dec_char_t item;
    step_n = 0;
    h      = hex_nibble(ch);
    is_oct = (ch >= bed_pkg::Ch0 && ch <= bed_pkg::Ch7);
    case (esc_phase)
      bed_pkg::PhBs: begin
        esc_phase = bed_pkg::PhIdle;
        case (ch)
          bed_pkg::ChE: put_byte(bed_pkg::CodeEsc);
          bed_pkg::ChF: put_byte(bed_pkg::CodeFf);
          bed_pkg::ChN: put_byte(bed_pkg::CodeLf);
          bed_pkg::ChR: put_byte(bed_pkg::CodeCr);
          bed_pkg::ChT: put_byte(bed_pkg::CodeTab);
          bed_pkg::ChBackslash: put_byte(bed_pkg::ChBackslash);
          bed_pkg::ChX: esc_phase = bed_pkg::PhX0;
          default: begin
            if (ch >= bed_pkg::Ch0 && ch <= bed_pkg::Ch3) begin
              held_lo   = ch;
              esc_value = ch - bed_pkg::Ch0;
              esc_phase = bed_pkg::PhO1;
            end else begin
              put_byte(bed_pkg::ChBackslash);
              scan_plain(ch);
            end
          end
        endcase
      end
      bed_pkg::PhX0: begin
        if (h >= 0) begin
          held_lo   = ch;
          esc_value = 8'(h);
          esc_phase = bed_pkg::PhX1;
        end else begin
          abandon_escape();
          scan_plain(ch);
        end
      end
      bed_pkg::PhX1: begin
        if (h >= 0) begin
          put_byte(8'(esc_value * 16 + h));
          esc_phase = bed_pkg::PhIdle;
        end else begin
          abandon_escape();
          scan_plain(ch);
        end
      end
      bed_pkg::PhO1: begin
        if (is_oct) begin
          held_hi   = ch;
          esc_value = 8'(esc_value * 8 + (ch - bed_pkg::Ch0));
          esc_phase = bed_pkg::PhO2;
        end else begin
          abandon_escape();
          scan_plain(ch);
        end
      end
      bed_pkg::PhO2: begin
        if (is_oct) begin
          put_byte(8'(esc_value * 8 + (ch - bed_pkg::Ch0)));
          esc_phase = bed_pkg::PhIdle;
        end else begin
          abandon_escape();
          scan_plain(ch);
        end
      end
      default: scan_plain(ch);
    endcase
    if (last) begin
      abandon_escape();
    end
    for (int i = 0; i < step_n; i++) begin
      item.ch   = step_bytes[i];
      item.last = last && (i == step_n - 1);
      decoded_q.insert(decoded_q.size(), item);
    end
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(bed_pkg::Ch0 + v);
    return ($urandom_range(0, 1) == 0) ? 8'(bed_pkg::ChLowA + v - 10)
                                       : 8'(bed_pkg::ChUpA + v - 10);
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.in_byte <= ch;
    in_if.in_last <= last;
    do @(posedge clk_i); while (!in_if.ready);
    decode_char(ch, last);
    chars_sent++;
  endtask

  task automatic send_string(input logic [7:0] text[$]);
    foreach (text[i]) begin
      send_char(text[i], i == text.size() - 1);
    end
    strings_sent++;
  endtask

  task automatic test_plain_extremes();
    send_string('{8'h00, 8'hFF});
  endtask

  task automatic test_simple_escapes();
    send_string('{bed_pkg::ChBackslash, bed_pkg::ChE, bed_pkg::ChBackslash, bed_pkg::ChF,
                  bed_pkg::ChBackslash, bed_pkg::ChR, bed_pkg::ChBackslash, bed_pkg::ChT,
                  bed_pkg::ChBackslash, bed_pkg::ChBackslash});
  endtask

  task automatic test_numeric_escapes();
    send_string('{bed_pkg::ChBackslash, bed_pkg::ChX, bed_pkg::ChUpF, bed_pkg::ChLowF,
                  bed_pkg::ChBackslash, bed_pkg::Ch3, bed_pkg::Ch7, bed_pkg::Ch7});
  endtask

  // A bad digit releases the escape and is scanned again, so a backslash reopens one.
  task automatic test_broken_escapes();
    send_string('{bed_pkg::ChBackslash, bed_pkg::ChX, "4", "g", bed_pkg::ChBackslash,
                  "1", "2", bed_pkg::ChBackslash, bed_pkg::ChN,
                  bed_pkg::ChBackslash, "q"});
  endtask

  task automatic test_open_escape_at_end();
    send_string('{bed_pkg::ChBackslash});
    send_string('{bed_pkg::ChBackslash, bed_pkg::ChX, "3"});
  endtask

  task automatic test_random_strings();
    int unsigned stop_at;
    int unsigned pick;
    stop_at = chars_sent + 170;
    while (chars_sent < stop_at) begin
      gen_text.delete();
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          add_gen(8'($urandom_range(0, 255)));
        end else if (pick < 45) begin
          add_gen(bed_pkg::ChBackslash);
          case ($urandom_range(0, 5))
            0: add_gen(bed_pkg::ChE);
            1: add_gen(bed_pkg::ChF);
            2: add_gen(bed_pkg::ChN);
            3: add_gen(bed_pkg::ChR);
            4: add_gen(bed_pkg::ChT);
            default: add_gen(bed_pkg::ChBackslash);
          endcase
        end else if (pick < 60) begin
          add_gen(bed_pkg::ChBackslash);
          add_gen(bed_pkg::ChX);
          add_gen(rand_hex_char());
          add_gen(rand_hex_char());
        end else if (pick < 75) begin
          add_gen(bed_pkg::ChBackslash);
          add_gen(8'(bed_pkg::Ch0 + $urandom_range(0, 3)));
          add_gen(8'(bed_pkg::Ch0 + $urandom_range(0, 7)));
          add_gen(8'(bed_pkg::Ch0 + $urandom_range(0, 7)));
        end else if (pick < 90) begin
          add_gen(bed_pkg::ChBackslash);
          case ($urandom_range(0, 4))
            0: ;
            1: add_gen(bed_pkg::ChX);
            2: begin
              add_gen(bed_pkg::ChX);
              add_gen(rand_hex_char());
            end
            3: add_gen(8'(bed_pkg::Ch0 + $urandom_range(0, 3)));
            default: begin
              add_gen(8'(bed_pkg::Ch0 + $urandom_range(0, 3)));
              add_gen(8'(bed_pkg::Ch0 + $urandom_range(0, 7)));
            end
          endcase
          case ($urandom_range(0, 3))
            0: ;
            1: add_gen(bed_pkg::ChBackslash);
            2: add_gen(8'($urandom_range(8'h67, 8'h7A)));
            default: add_gen(8'($urandom_range(0, 255)));
          endcase
        end else begin
          add_gen(bed_pkg::ChBackslash);
          add_gen(8'($urandom_range(0, 255)));
        end
      end
      send_string(gen_text);
    end
  endtask

  always @(posedge clk_i) begin
    if (mode_cycles == 0) begin
      stall_mode  <= 2'($urandom_range(0, 3));
      mode_cycles <= $urandom_range(20, 80);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    stall_phase <= stall_phase + 4'd1;
    case (stall_mode)
      2'd0: out_if.ready <= 1'b1;
      2'd1: out_if.ready <= ($urandom_range(0, 1) == 0);
      2'd2: out_if.ready <= (stall_phase[1:0] == 2'd0);
      default: out_if.ready <= (stall_phase >= 4'd8);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got byte %h last %b",
                 $time, out_if.out_byte, out_if.out_last);
        err_count++;
      end else begin
        want_char = decoded_q.pop_front();
        if (out_if.out_byte !== want_char.ch) begin
          $display("%0t: out_byte mismatch: expected %h, got %h",
                   $time, want_char.ch, out_if.out_byte);
          err_count++;
        end
        if (out_if.out_last !== want_char.last) begin
          $display("%0t: out_last mismatch: expected %b, got %b",
                   $time, want_char.last, out_if.out_last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    in_if.in_last = 1'b0;
    out_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_extremes();
    test_simple_escapes();
    test_numeric_escapes();
    test_broken_escapes();
    test_open_escape_at_end();
    test_random_strings();

    in_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d characters in %0d strings and checked %0d decoded characters,",
             chars_sent, strings_sent, results_seen);
    $display("covering named, hex and octal escapes, broken escapes and open escapes at end.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
